// File: rtl/array_stack_with_reverse_top_assert.svh
// Assertion helpers used by the stack datapath.
// Every check is clocked on aclk and held off while aresetn is low.
`ifndef ARRAY_STACK_WITH_REVERSE_TOP_ASSERT_SVH
`define ARRAY_STACK_WITH_REVERSE_TOP_ASSERT_SVH

// Same-cycle implication.
`define ASR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/asr_pkg.sv
`timescale 1ns / 1ps

package asr_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 8;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2,
        ACT_REV  = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_SINGLE = 2'd3
    } stat_t;

    typedef struct packed {
        act_t                     action;
        logic signed [WORD_W-1:0] data;
    } asr_in_t;

    typedef struct packed {
        stat_t                    status;
        logic signed [WORD_W-1:0] value;
        logic [COUNT_W-1:0]       count;
        logic                     empty_res;
    } asr_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_REV_RD_LO,
        S_REV_RD_HI,
        S_REV_WR_HI,
        S_REV_WR_LO,
        S_RESP
    } asr_state_t;

    // controller -> datapath
    typedef struct packed {
        logic  capture;
        logic  push;
        logic  rd_top;
        logic  pop;
        logic  rev_init;
        logic  rd_lo;
        logic  rd_hi;
        logic  wr_hi;
        logic  wr_lo;
        logic  set_res;
        stat_t res_status;
        logic  res_neg;
        logic  res_rdata;
        logic  load_out;
    } asr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        act_t action;
        logic fill_zero;
        logic fill_one;
        logic fill_full;
        logic rev_more;
        logic out_free;
    } asr_sts_t;

endpackage

// File: rtl/asr_ctrl.sv
`timescale 1ns / 1ps

module asr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  asr_pkg::asr_sts_t sts,
    output asr_pkg::asr_cmd_t cmd
);
    import asr_pkg::*;

    asr_state_t state_reg;
    asr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (sts.action)
                    ACT_POP, ACT_PEEK: begin
                        state_next = sts.fill_zero ? S_RESP : S_RD_WAIT;
                    end
                    ACT_REV: begin
                        if (sts.fill_zero || sts.fill_one) begin
                            state_next = S_RESP;
                        end else begin
                            state_next = S_REV_RD_LO;
                        end
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_RD_WAIT:   state_next = S_RESP;
            S_REV_RD_LO: state_next = S_REV_RD_HI;
            S_REV_RD_HI: state_next = S_REV_WR_HI;
            S_REV_WR_HI: state_next = S_REV_WR_LO;
            S_REV_WR_LO: begin
                state_next = sts.rev_more ? S_REV_RD_LO : S_RESP;
            end
            S_RESP: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_EXEC: begin
                unique case (sts.action)
                    ACT_PUSH: begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = sts.fill_full ? ST_FULL : ST_OK;
                        cmd.push       = !sts.fill_full;
                    end
                    ACT_POP, ACT_PEEK: begin
                        if (sts.fill_zero) begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = ST_EMPTY;
                            cmd.res_neg    = 1'b1;
                        end else begin
                            cmd.rd_top = 1'b1;
                            cmd.pop    = (sts.action == ACT_POP);
                        end
                    end
                    default: begin
                        cmd.set_res = 1'b1;
                        if (sts.fill_zero) begin
                            cmd.res_status = ST_EMPTY;
                            cmd.res_neg    = 1'b1;
                        end else if (sts.fill_one) begin
                            cmd.res_status = ST_SINGLE;
                        end else begin
                            cmd.res_status = ST_OK;
                            cmd.rev_init   = 1'b1;
                        end
                    end
                endcase
            end
            S_RD_WAIT:   cmd.res_rdata = 1'b1;
            S_REV_RD_LO: cmd.rd_lo     = 1'b1;
            S_REV_RD_HI: cmd.rd_hi     = 1'b1;
            S_REV_WR_HI: cmd.wr_hi     = 1'b1;
            S_REV_WR_LO: cmd.wr_lo     = 1'b1;
            S_RESP:      cmd.load_out  = sts.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/asr_dpath.sv
`timescale 1ns / 1ps

module asr_dpath #(
    parameter int DEPTH = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  asr_pkg::asr_in_t   s_payload,
    input  logic               m_ready,
    output logic               m_valid,
    output asr_pkg::asr_out_t  m_payload,
    input  asr_pkg::asr_cmd_t  cmd,
    output asr_pkg::asr_sts_t  sts
);
    import asr_pkg::*;

    `include "array_stack_with_reverse_top_assert.svh"

    localparam int AW  = $clog2(DEPTH);
    localparam int AW1 = AW + 1;
    localparam int CW  = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] mem [DEPTH];

    act_t              act_reg;
    logic [WORD_W-1:0] data_reg;
    logic [CW-1:0]     fill_reg;
    logic [CW-1:0]     fill_next;
    logic [AW-1:0]     lo_reg;
    logic [AW-1:0]     lo_next;
    logic [AW-1:0]     hi_reg;
    logic [AW-1:0]     hi_next;
    logic [WORD_W-1:0] rdata_reg;
    logic [WORD_W-1:0] hold_reg;
    stat_t             res_status_reg;
    logic [WORD_W-1:0] res_value_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    asr_out_t          m_payload_reg;

    logic [AW-1:0]     top_idx;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    assign top_idx = AW'(fill_reg - CW'(1));

    // status back to the controller
    assign sts.action    = act_reg;
    assign sts.fill_zero = (fill_reg == '0);
    assign sts.fill_one  = (fill_reg == CW'(1));
    assign sts.fill_full = (fill_reg == CW'(DEPTH));
    assign sts.rev_more  = (({1'b0, lo_reg} + AW1'(2)) < {1'b0, hi_reg});
    assign sts.out_free  = !m_valid_reg || m_ready;

    // memory ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = fill_reg[AW-1:0];
        mem_wdata = data_reg;
        if (cmd.push) begin
            mem_we = 1'b1;
        end else if (cmd.wr_hi) begin
            mem_we    = 1'b1;
            mem_waddr = hi_reg;
            mem_wdata = hold_reg;
        end else if (cmd.wr_lo) begin
            mem_we    = 1'b1;
            mem_waddr = lo_reg;
            mem_wdata = rdata_reg;
        end
    end

    always_comb begin
        mem_re    = cmd.rd_top || cmd.rd_lo || cmd.rd_hi;
        mem_raddr = top_idx;
        if (cmd.rd_lo) begin
            mem_raddr = lo_reg;
        end else if (cmd.rd_hi) begin
            mem_raddr = hi_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // fill count and swap pointers
    always_comb begin
        fill_next = fill_reg;
        if (cmd.push) begin
            fill_next = fill_reg + CW'(1);
        end else if (cmd.pop) begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.rev_init) begin
            lo_next = '0;
            hi_next = top_idx;
        end else if (cmd.wr_lo) begin
            lo_next = lo_reg + AW'(1);
            hi_next = hi_reg - AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid_next = cmd.load_out ? 1'b1 : (m_valid_reg && !m_ready);

    // payload registers
    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (cmd.capture) begin
            act_reg  <= s_payload.action;
            data_reg <= s_payload.data;
        end
        if (cmd.rd_hi) begin
            hold_reg <= rdata_reg;
        end
        if (cmd.set_res) begin
            res_status_reg <= cmd.res_status;
            res_value_reg  <= cmd.res_neg ? '1 : '0;
        end else if (cmd.res_rdata) begin
            res_status_reg <= ST_OK;
            res_value_reg  <= rdata_reg;
        end
        if (cmd.load_out) begin
            m_payload_reg.status    <= res_status_reg;
            m_payload_reg.value     <= res_value_reg;
            m_payload_reg.count     <= COUNT_W'(fill_reg);
            m_payload_reg.empty_res <= (fill_reg == '0);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `ASR_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CW'(DEPTH), "fill above depth")
    `ASR_ASSERT_NXT(a_push_grows, cmd.push, fill_reg == $past(fill_reg) + CW'(1), "push lost")
    `ASR_ASSERT_IMP(a_swap_order, cmd.rd_lo, lo_reg < hi_reg, "swap pointers crossed")
    `ASR_ASSERT_IMP(a_slot_free, cmd.load_out, !m_valid_reg || m_ready, "result overwritten")

endmodule

// File: rtl/array_stack_with_reverse_top.sv
`timescale 1ns / 1ps

// Bounded LIFO stack of DEPTH signed 32-bit words with push, pop, peek and
// in-place reverse. One request is taken at a time and gives exactly one
// result beat holding a status code, the popped or top word (-1 on an empty
// stack), the fill count after the request and an empty flag. A push, or any
// request that ends in an error, goes from the execute state straight to the
// response state. Pop and peek pass through a read-wait state first,
// because the top word is read through the registered read port of the
// single-port-write storage array. A reverse of n >= 2 words steps through
// the read-low, read-high, write-high and write-low states once per swapped
// pair, floor(n / 2) pairs in all: each swapped pair needs two reads and two
// writes on the one read and one write port of the array. The input is taken
// again once the result is moved into the output register, so a new request
// may be accepted while the previous result still waits on m_ready; the
// following result then stalls the block until the output register frees up.
// Stored words need no reset; only the fill count, the output valid flag and the controller state are cleared.
module array_stack_with_reverse_top #(
    parameter int DEPTH = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    // request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  asr_pkg::asr_in_t  s_payload,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output asr_pkg::asr_out_t m_payload
);
    import asr_pkg::*;

    asr_cmd_t cmd;  // controller commands for this cycle
    asr_sts_t sts;  // flags the controller branches on

    // sequencer: request decode, reverse swap loop, result hand-off
    asr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // storage array, fill count, swap pointers and output register
    asr_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_payload (m_payload),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
